/* rtl/core/rleb_pkg.sv */
package rleb_pkg;

    // Bar geometry
    localparam int LED_COUNT    = 15;
    localparam int COLUMN_COUNT = 13;
    localparam int TABLE_SIZE   = 13;
    localparam int LED_W        = $clog2(LED_COUNT);
    localparam int COL_LIMIT    = (COLUMN_COUNT < TABLE_SIZE) ? COLUMN_COUNT : TABLE_SIZE;

    // Column to centre LED map
    localparam logic [7:0] COLUMN_LED [TABLE_SIZE] = '{
        8'd0, 8'd1, 8'd3, 8'd4, 8'd5, 8'd6, 8'd8, 8'd9, 8'd10, 8'd11, 8'd13, 8'd14, 8'd0
    };

    localparam logic [7:0] ENERGY_MAX = 8'hFF;

    // Item opcodes
    localparam logic OPC_PRESS = 1'b0;
    localparam logic OPC_FRAME = 1'b1;

    // Steps of a key press
    localparam logic [1:0] OP_CENTRE = 2'd0;
    localparam logic [1:0] OP_LEFT   = 2'd1;
    localparam logic [1:0] OP_RIGHT  = 2'd2;

    // Register map
    typedef enum logic [2:0] {
        CFG_HIT          = 3'd0,
        CFG_NEIGHBOR     = 3'd1,
        CFG_HOLD         = 3'd2,
        CFG_HOLD_NEIGHB  = 3'd3,
        CFG_FADE         = 3'd4,
        CFG_MAX_BRIGHT   = 3'd5,
        CFG_REVERSE      = 3'd6
    } cfg_idx_t;

    localparam logic [7:0] RST_HIT         = 8'd192;
    localparam logic [7:0] RST_NEIGHBOR    = 8'd64;
    localparam logic [7:0] RST_HOLD        = 8'd128;
    localparam logic [7:0] RST_HOLD_NEIGHB = 8'd48;
    localparam logic [7:0] RST_FADE        = 8'd8;
    localparam logic [7:0] RST_MAX_BRIGHT  = 8'd255;
    localparam logic       RST_REVERSE     = 1'b0;

    // Shared unit operations
    typedef enum logic [1:0] {
        ALU_ADD  = 2'b01,
        ALU_FADE = 2'b10
    } alu_op_t;

    typedef struct packed {
        logic        opcode;
        logic [3:0]  key_column;
        logic [7:0]  frames_elapsed;
        logic [12:0] held_columns;
    } rleb_in_t;

    typedef struct packed {
        logic [3:0] led_index;
        logic [7:0] brightness;
        logic       last;
        logic       still_lit;
    } rleb_out_t;

    // Table lookup with constant compare per entry
    function automatic logic [7:0] column_to_led(input logic [3:0] col);
        logic [7:0] led;
        led = '0;
        for (int k = 0; k < TABLE_SIZE; k++) begin
            if (32'(col) == k) begin
                led = COLUMN_LED[k];
            end
        end
        return led;
    endfunction

endpackage

/* rtl/core/rleb_ram.sv */
module rleb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/rleb_alu.sv */
module rleb_alu (
    input  rleb_pkg::alu_op_t op,
    input  logic [7:0]        a,
    input  logic [7:0]        b,
    input  logic [7:0]        c,
    output logic [7:0]        y
);
    import rleb_pkg::*;

    logic [8:0] sum;
    logic [7:0] faded;

    // Saturating add; floored subtract then raise to floor c
    always_comb begin
        sum   = {1'b0, a} + {1'b0, b};
        faded = (a > b) ? (a - b) : 8'd0;
        unique case (op)
            ALU_ADD:  y = sum[8] ? ENERGY_MAX : sum[7:0];
            ALU_FADE: y = (faded < c) ? c : faded;
            default:  y = a;
        endcase
    end

endmodule

/* rtl/core/reactive_led_energy_bar_top.sv */
// Channel   | Direction | Handshake         | Payload
// s_        | in        | s_valid / s_ready | rleb_in_t  (press or frame item)
// m_        | out       | m_valid / m_ready | rleb_out_t (one LED per transfer)
// cfg_      | in        | cfg_wr_en         | cfg_addr, cfg_wdata
//
// Key press: an accept step, a read step for each of the three LED slots, plus a
// write step per touched LED; an ignored press touches none.
// Frame: an accept step, a read and a write step per LED to fade, then a read and an
// emit step per LED to render, paced by the single read and write port of the energy RAM.
// Output stalls stretch the render pass; s_ready is low until the last LED is loaded.
// Reset (aresetn, synchronous) clears config, control and per-LED valid bits at once.
module reactive_led_energy_bar_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  rleb_pkg::rleb_in_t  s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output rleb_pkg::rleb_out_t m_payload,
    input  logic                cfg_wr_en,
    input  logic [2:0]          cfg_addr,
    input  logic [7:0]          cfg_wdata
);
    import rleb_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_P_RD   = 7'b0000010,
        ST_P_WR   = 7'b0000100,
        ST_F_RD   = 7'b0001000,
        ST_F_WR   = 7'b0010000,
        ST_R_RD   = 7'b0100000,
        ST_R_EMIT = 7'b1000000
    } state_t;

    localparam logic [LED_W-1:0] LED_LAST = LED_W'(LED_COUNT - 1);

    state_t state_reg, state_next;

    // Configuration registers
    logic [7:0] hit_reg, nb_inc_reg, hold_reg, hold_nb_reg, fade_step_reg, max_b_reg;
    logic       reverse_reg;

    // Item context
    logic [LED_W-1:0]     centre_reg, centre_next;
    logic [2:0]           ops_reg, ops_next;
    logic [1:0]           op_idx_reg, op_idx_next;
    logic [LED_W-1:0]     led_idx_reg, led_idx_next;
    logic [7:0]           fade_amt_reg, fade_amt_next;
    logic [LED_COUNT-1:0] cmask_reg, cmask_next;
    logic [LED_COUNT-1:0] nmask_reg, nmask_next;

    // Per-LED state beside the RAM
    logic [LED_COUNT-1:0] valid_reg, nz_reg;
    logic                 rd_valid_reg;

    // Output slot
    logic      m_valid_reg, m_valid_next;
    rleb_out_t m_payload_reg, m_payload_next;

    // RAM and shared unit
    logic             ram_we, ram_re;
    logic [LED_W-1:0] ram_waddr, ram_raddr, op_addr;
    logic [7:0]       ram_wdata, ram_rdata, energy;
    alu_op_t          alu_op;
    logic [7:0]       alu_b, alu_c, alu_y, floor_lvl;

    logic             accept, out_free;
    logic [7:0]       press_led;
    logic             press_ok;
    logic [15:0]      fade_prod;
    logic [16:0]      bright_prod;
    logic [LED_W-1:0] drv;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign energy   = rd_valid_reg ? ram_rdata : 8'd0;

    rleb_ram #(
        .WIDTH (8),
        .DEPTH (LED_COUNT)
    ) u_energy_ram (
        .clk     (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    rleb_alu u_alu (
        .op (alu_op),
        .a  (energy),
        .b  (alu_b),
        .c  (alu_c),
        .y  (alu_y)
    );

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg       <= RST_HIT;
            nb_inc_reg    <= RST_NEIGHBOR;
            hold_reg      <= RST_HOLD;
            hold_nb_reg   <= RST_HOLD_NEIGHB;
            fade_step_reg <= RST_FADE;
            max_b_reg     <= RST_MAX_BRIGHT;
            reverse_reg   <= RST_REVERSE;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_HIT:         hit_reg       <= cfg_wdata;
                CFG_NEIGHBOR:    nb_inc_reg    <= cfg_wdata;
                CFG_HOLD:        hold_reg      <= cfg_wdata;
                CFG_HOLD_NEIGHB: hold_nb_reg   <= cfg_wdata;
                CFG_FADE:        fade_step_reg <= cfg_wdata;
                CFG_MAX_BRIGHT:  max_b_reg     <= cfg_wdata;
                CFG_REVERSE:     reverse_reg   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Decode of an incoming item
    always_comb begin
        press_led = column_to_led(s_payload.key_column);
        press_ok  = (int'(s_payload.key_column) < COL_LIMIT) && (int'(press_led) < LED_COUNT);
        fade_prod = 16'(s_payload.frames_elapsed) * 16'(fade_step_reg);
        cmask_next = '0;
        for (int c = 0; c < COL_LIMIT; c++) begin
            if (s_payload.held_columns[c] && (int'(COLUMN_LED[c]) < LED_COUNT)) begin
                cmask_next[COLUMN_LED[c][LED_W-1:0]] = 1'b1;
            end
        end
        nmask_next = (cmask_next << 1) | (cmask_next >> 1);
    end

    // Address of the current press step
    always_comb begin
        case (op_idx_reg)
            OP_CENTRE: op_addr = centre_reg;
            OP_LEFT:   op_addr = centre_reg - LED_W'(1);
            default:   op_addr = centre_reg + LED_W'(1);
        endcase
    end

    // Hold floor of the LED in the fade pass
    always_comb begin
        if (cmask_reg[led_idx_reg] && nmask_reg[led_idx_reg]) begin
            floor_lvl = (hold_reg > hold_nb_reg) ? hold_reg : hold_nb_reg;
        end else if (cmask_reg[led_idx_reg]) begin
            floor_lvl = hold_reg;
        end else if (nmask_reg[led_idx_reg]) begin
            floor_lvl = hold_nb_reg;
        end else begin
            floor_lvl = 8'd0;
        end
    end

    // Brightness and driver index of the LED being rendered
    always_comb begin
        bright_prod = 17'(energy) * (17'(max_b_reg) + 17'd1);
        drv         = reverse_reg ? (LED_LAST - led_idx_reg) : led_idx_reg;
    end

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        centre_next    = centre_reg;
        ops_next       = ops_reg;
        op_idx_next    = op_idx_reg;
        led_idx_next   = led_idx_reg;
        fade_amt_next  = fade_amt_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_payload_next = m_payload_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_waddr      = led_idx_reg;
        ram_raddr      = led_idx_reg;
        ram_wdata      = alu_y;
        alu_op         = ALU_FADE;
        alu_b          = fade_amt_reg;
        alu_c          = floor_lvl;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    op_idx_next  = OP_CENTRE;
                    led_idx_next = '0;
                    if (s_payload.opcode == OPC_FRAME) begin
                        fade_amt_next = (|fade_prod[15:8]) ? ENERGY_MAX : fade_prod[7:0];
                        state_next    = ST_F_RD;
                    end else begin
                        centre_next = press_led[LED_W-1:0];
                        ops_next[0] = press_ok;
                        ops_next[1] = press_ok && (press_led != 8'd0);
                        ops_next[2] = press_ok && (int'(press_led) + 1 < LED_COUNT);
                        state_next  = ST_P_RD;
                    end
                end
            end
            ST_P_RD: begin
                ram_raddr = op_addr;
                if (ops_reg[op_idx_reg]) begin
                    ram_re     = 1'b1;
                    state_next = ST_P_WR;
                end else if (op_idx_reg == OP_RIGHT) begin
                    state_next = ST_IDLE;
                end else begin
                    op_idx_next = op_idx_reg + 2'd1;
                end
            end
            ST_P_WR: begin
                alu_op    = ALU_ADD;
                alu_b     = (op_idx_reg == OP_CENTRE) ? hit_reg : nb_inc_reg;
                ram_we    = 1'b1;
                ram_waddr = op_addr;
                if (op_idx_reg == OP_RIGHT) begin
                    state_next = ST_IDLE;
                end else begin
                    op_idx_next = op_idx_reg + 2'd1;
                    state_next  = ST_P_RD;
                end
            end
            ST_F_RD: begin
                ram_re     = 1'b1;
                state_next = ST_F_WR;
            end
            ST_F_WR: begin
                ram_we = 1'b1;
                if (led_idx_reg == LED_LAST) begin
                    led_idx_next = '0;
                    state_next   = ST_R_RD;
                end else begin
                    led_idx_next = led_idx_reg + LED_W'(1);
                    state_next   = ST_F_RD;
                end
            end
            ST_R_RD: begin
                ram_re     = 1'b1;
                state_next = ST_R_EMIT;
            end
            ST_R_EMIT: begin
                if (out_free) begin
                    m_valid_next              = 1'b1;
                    m_payload_next.led_index  = 4'(drv);
                    m_payload_next.brightness = bright_prod[15:8];
                    m_payload_next.last       = (led_idx_reg == LED_LAST);
                    m_payload_next.still_lit  = |nz_reg;
                    if (led_idx_reg == LED_LAST) begin
                        state_next = ST_IDLE;
                    end else begin
                        led_idx_next = led_idx_reg + LED_W'(1);
                        state_next   = ST_R_RD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            valid_reg   <= '0;
            nz_reg      <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (ram_we) begin
                valid_reg[ram_waddr] <= 1'b1;
                nz_reg[ram_waddr]    <= (ram_wdata != 8'd0);
            end
        end
    end

    // Item context and payload
    always_ff @(posedge aclk) begin
        centre_reg    <= centre_next;
        ops_reg       <= ops_next;
        op_idx_reg    <= op_idx_next;
        led_idx_reg   <= led_idx_next;
        fade_amt_reg  <= fade_amt_next;
        m_payload_reg <= m_payload_next;
        if (accept) begin
            cmask_reg <= cmask_next;
            nmask_reg <= nmask_next;
        end
        if (ram_re) begin
            rd_valid_reg <= valid_reg[ram_raddr];
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

/* rtl/core/rleb_chk.sv */
module rleb_chk (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input rleb_pkg::rleb_in_t  s_payload,
    input logic                m_valid,
    input logic                m_ready,
    input rleb_pkg::rleb_out_t m_payload
);
    import rleb_pkg::*;

    // Each accepted item occupies the sequencer, which closes the input
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted on consecutive cycles");

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_payload)))
        else $error("result changed while stalled");

    // Mid-frame results keep the input closed
    a_frame_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_payload.last) |-> !s_ready)
        else $error("input open during a frame render");

    // A dark bar renders zero brightness
    a_dark: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_payload.still_lit) |-> (m_payload.brightness == 8'd0))
        else $error("nonzero brightness with bar dark");

endmodule

bind reactive_led_energy_bar_top rleb_chk u_rleb_chk (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_payload (s_payload),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);

/* test/reactive_led_energy_bar_top_tb.sv */
module reactive_led_energy_bar_top_tb;
    import rleb_pkg::*;

    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 80;
    localparam int CHUNK_ITEMS     = 70;
    localparam int CHUNK_COUNT     = 6;
    localparam logic [2:0] CFG_SPARE = 3'd7;

    // Centre LED of each key column
    localparam logic [3:0] CENTRE_OF_COLUMN [COLUMN_COUNT] = '{
        4'd0, 4'd1, 4'd3, 4'd4, 4'd5, 4'd6, 4'd8, 4'd9, 4'd10, 4'd11, 4'd13, 4'd14, 4'd0
    };

    logic      aclk;
    logic      aresetn   = 1'b0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    rleb_in_t  s_payload = '0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    rleb_out_t m_payload;
    logic       cfg_wr_en = 1'b0;
    logic [2:0] cfg_addr  = '0;
    logic [7:0] cfg_wdata = '0;

    reactive_led_energy_bar_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Shadow of the bar: energy per LED and register values
    logic [7:0] led_level [LED_COUNT];
    logic [7:0] hit_inc      = 8'd192;
    logic [7:0] nbr_inc      = 8'd64;
    logic [7:0] hold_lvl     = 8'd128;
    logic [7:0] hold_nbr_lvl = 8'd48;
    logic [7:0] fade_amt     = 8'd8;
    logic [7:0] max_bright   = 8'd255;
    logic       rev_en       = 1'b0;

    rleb_in_t  pending_items [$];
    rleb_out_t expected_leds [$];

    int items_issued      = 0;
    int items_accepted    = 0;
    int press_count       = 0;
    int frame_count       = 0;
    int led_results       = 0;
    int settings_applied  = 0;
    int error_count       = 0;
    int send_idle_pct     = 13;
    int recv_idle_pct     = 74;
    int hold_off_requests = 0;
    int hold_off_granted  = 0;
    int hold_off_left     = 0;

    initial begin
        for (int i = 0; i < LED_COUNT; i++) led_level[i] = 8'd0;
    end

    task automatic flag_error(input string msg);
        error_count++;
        $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    // Saturating add and hold floor on one LED
    function automatic void bump_led(input int led, input logic [7:0] amount);
        int sum;
        sum = int'(led_level[led]) + int'(amount);
        led_level[led] = (sum > 255) ? 8'hFF : 8'(sum);
    endfunction

    function automatic void raise_led(input int led, input logic [7:0] floor_lvl);
        if (led_level[led] < floor_lvl) led_level[led] = floor_lvl;
    endfunction

    function automatic void touch_column(input int col, input bit is_press);
        int centre;
        centre = int'(CENTRE_OF_COLUMN[col]);
        if (centre >= LED_COUNT) return;
        if (is_press) begin
            bump_led(centre, hit_inc);
            if (centre > 0) bump_led(centre - 1, nbr_inc);
            if (centre + 1 < LED_COUNT) bump_led(centre + 1, nbr_inc);
        end else begin
            raise_led(centre, hold_lvl);
            if (centre > 0) raise_led(centre - 1, hold_nbr_lvl);
            if (centre + 1 < LED_COUNT) raise_led(centre + 1, hold_nbr_lvl);
        end
    endfunction

    // Update the bar for one item; a frame queues one brightness per LED
    function automatic void update_bar(input rleb_in_t item);
        int        fade;
        int        bright;
        bit        lit;
        rleb_out_t res;
        if (item.opcode == OPC_PRESS) begin
            press_count++;
            if (int'(item.key_column) < COLUMN_COUNT) touch_column(int'(item.key_column), 1'b1);
            return;
        end
        frame_count++;
        fade = int'(item.frames_elapsed) * int'(fade_amt);
        if (fade > 255) fade = 255;
        for (int i = 0; i < LED_COUNT; i++)
            led_level[i] = (int'(led_level[i]) > fade) ? 8'(int'(led_level[i]) - fade) : 8'd0;
        for (int c = 0; c < COLUMN_COUNT; c++)
            if (item.held_columns[c]) touch_column(c, 1'b0);
        lit = 1'b0;
        for (int i = 0; i < LED_COUNT; i++)
            if (led_level[i] != 8'd0) lit = 1'b1;
        for (int i = 0; i < LED_COUNT; i++) begin
            bright = (int'(led_level[i]) * (int'(max_bright) + 1)) >> 8;
            res.led_index  = 4'(rev_en ? LED_COUNT - 1 - i : i);
            res.brightness = 8'(bright);
            res.last       = (i == LED_COUNT - 1);
            res.still_lit  = lit;
            expected_leds.push_back(res);
        end
    endfunction

    // Input driver: one transfer per handshake, random gaps
    always @(posedge aclk) begin : item_driver
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                update_bar(s_payload);
                items_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid   <= 1'b1;
                    s_payload <= pending_items.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here
    always @(posedge aclk) begin : hold_off_counter
        if (hold_off_granted != hold_off_requests) begin
            hold_off_granted <= hold_off_requests;
            hold_off_left    <= HOLD_OFF_CYCLES;
        end else if (hold_off_left != 0) begin
            hold_off_left <= hold_off_left - 1;
        end
    end

    // Result monitor: compare each transfer with the oldest expected LED
    always @(posedge aclk) begin : result_monitor
        rleb_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                led_results++;
                if (expected_leds.size() == 0) begin
                    flag_error($sformatf("unexpected result, led_index %0d brightness %0d",
                                         m_payload.led_index, m_payload.brightness));
                end else begin
                    want = expected_leds.pop_front();
                    if (m_payload.led_index !== want.led_index)
                        flag_error($sformatf("led_index %0d, want %0d",
                                             m_payload.led_index, want.led_index));
                    if (m_payload.brightness !== want.brightness)
                        flag_error($sformatf("brightness %0d, want %0d (led_index %0d)",
                                             m_payload.brightness, want.brightness,
                                             want.led_index));
                    if (m_payload.last !== want.last)
                        flag_error($sformatf("last %b, want %b (led_index %0d)",
                                             m_payload.last, want.last, want.led_index));
                    if (m_payload.still_lit !== want.still_lit)
                        flag_error($sformatf("still_lit %b, want %b (led_index %0d)",
                                             m_payload.still_lit, want.still_lit,
                                             want.led_index));
                end
            end
            m_ready <= (hold_off_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic queue_item(input rleb_in_t item);
        pending_items.push_back(item);
        items_issued++;
    endtask

    function automatic rleb_in_t random_item();
        rleb_in_t it;
        it.opcode         = 1'($urandom_range(1));
        it.key_column     = 4'($urandom_range(15));
        it.frames_elapsed = 8'($urandom_range(255));
        it.held_columns   = 13'($urandom_range(8191));
        if ($urandom_range(99) < 60) begin
            it.opcode = OPC_PRESS;
            if ($urandom_range(9) != 0) it.key_column = 4'($urandom_range(COLUMN_COUNT - 1));
        end else begin
            it.opcode = OPC_FRAME;
            case ($urandom_range(3))
                0: it.frames_elapsed = 8'd0;
                1, 2: it.frames_elapsed = 8'($urandom_range(3));
                default: ;
            endcase
            case ($urandom_range(3))
                0: it.held_columns = '0;
                1: it.held_columns = 13'd1 << $urandom_range(COLUMN_COUNT - 1);
                default: ;
            endcase
        end
        return it;
    endfunction

    // Everything accepted, every LED back, then let a key press settle
    task automatic wait_drained();
        while (items_accepted != items_issued || expected_leds.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [7:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        case (addr)
            CFG_HIT:         hit_inc      = value;
            CFG_NEIGHBOR:    nbr_inc      = value;
            CFG_HOLD:        hold_lvl     = value;
            CFG_HOLD_NEIGHB: hold_nbr_lvl = value;
            CFG_FADE:        fade_amt     = value;
            CFG_MAX_BRIGHT:  max_bright   = value;
            CFG_REVERSE:     rev_en       = value[0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [7:0] hit, input logic [7:0] nbr,
                                  input logic [7:0] hold, input logic [7:0] hold_nbr,
                                  input logic [7:0] fade, input logic [7:0] bright,
                                  input logic rev);
        write_reg(CFG_HIT, hit);
        write_reg(CFG_NEIGHBOR, nbr);
        write_reg(CFG_HOLD, hold);
        write_reg(CFG_HOLD_NEIGHB, hold_nbr);
        write_reg(CFG_FADE, fade);
        write_reg(CFG_MAX_BRIGHT, bright);
        write_reg(CFG_REVERSE, {7'd0, rev});
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        settings_applied++;
    endtask

    initial begin : stimulus
        int base;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: dark frame, every column, saturation, full hold, full fade
        queue_item('{OPC_FRAME, 4'($urandom), 8'd0, 13'd0});
        for (int c = 0; c < 16; c++)
            queue_item('{OPC_PRESS, 4'(c), 8'($urandom), 13'($urandom)});
        queue_item('{OPC_FRAME, 4'($urandom), 8'd0, 13'd0});
        queue_item('{OPC_PRESS, 4'd5, 8'hFF, 13'h1FFF});
        queue_item('{OPC_PRESS, 4'd5, 8'h00, 13'h0000});
        queue_item('{OPC_FRAME, 4'hF, 8'd255, 13'h1FFF});
        queue_item('{OPC_FRAME, 4'h0, 8'd1, 13'h0000});
        queue_item('{OPC_FRAME, 4'($urandom), 8'd255, 13'h0000});
        wait_drained();

        // Random chunks, each under its own register setting
        for (int ch = 0; ch < CHUNK_COUNT; ch++) begin
            case (ch)
                0, 1: begin send_idle_pct = 13; recv_idle_pct = 74; end
                2, 3: begin send_idle_pct = 74; recv_idle_pct = 13; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            if (ch == 2) begin
                write_reg(CFG_SPARE, 8'($urandom));
            end
            case (ch)
                1: apply_settings(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
                3: apply_settings(8'd0, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0, 1'b0);
                default: apply_settings(8'($urandom), 8'($urandom), 8'($urandom_range(255, 1)),
                                        8'($urandom), 8'($urandom_range(40)),
                                        8'($urandom), 1'($urandom));
            endcase
            base = items_accepted;
            repeat (CHUNK_ITEMS) queue_item(random_item());
            if (ch == 0 || ch == 4) begin
                while (items_accepted < base + 3) @(posedge aclk);
                hold_off_requests++;
            end
            wait_drained();
        end

        $display("Covered %0d items (%0d presses, %0d frames), %0d LED results checked,",
                 items_accepted, press_count, frame_count, led_results);
        $display("over %0d register settings plus reset values, %0d errors",
                 settings_applied, error_count);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("Timeout: %0d of %0d items accepted, %0d results outstanding",
                 items_accepted, items_issued, expected_leds.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
